@@ hw/rtl/lkv_pkg.sv @@
// lkv_pkg: shared types and constants of the LRU key/value cache.
// Used by lkv_cell and lru_key_value_cache; depends on nothing.
`default_nettype none

package lkv_pkg;

   // Field widths fixed by the channel format
   localparam int ACTION_W  = 2;
   localparam int KEY_SPACE = 256;
   localparam int KEY_W     = $clog2(KEY_SPACE);
   localparam int DATA_W    = 32;
   localparam int STATUS_W  = 3;
   localparam int CFG_W     = 5;

   // Capacity register after reset
   localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

   // Request actions
   localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_GET   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EVICTED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_HIT      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

   // Control from the top level into one cell
   typedef struct packed {
      logic shift;   // take the left neighbour's entry this cycle
      logic valid;   // cell holds a live entry
   } lkv_cell_ctl_type;

   // Status from one cell back to the top level
   typedef struct packed {
      logic match;   // live entry whose key equals the request key
      logic seen;    // a match at this cell or any cell to its left
   } lkv_cell_stat_type;

endpackage

`default_nettype wire

@@ hw/rtl/lkv_cell.sv @@
// lkv_cell: one recency position of the LRU chain, holding a key and a value.
// Depends on lkv_pkg; instantiated by lru_key_value_cache.
`default_nettype none

module lkv_cell
   import lkv_pkg::*;
#(
   parameter int VW = 32
) (
   input  wire logic              clock,
   input  wire lkv_cell_ctl_type  ctl,
   input  wire logic [KEY_W-1:0]  left_key,
   input  wire logic [VW-1:0]     left_value,
   input  wire logic [KEY_W-1:0]  cmp_key,
   input  wire logic              seen_in,
   output logic [KEY_W-1:0]       key,
   output logic [VW-1:0]          value,
   output lkv_cell_stat_type      stat
);

   logic [KEY_W-1:0] key_ff, key_in;
   logic [VW-1:0]    value_ff, value_in;
   logic             match;

   // Shift in from the left neighbour or hold
   always_comb begin
      key_in   = ctl.shift ? left_key   : key_ff;
      value_in = ctl.shift ? left_value : value_ff;
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   // Key compare and the running "already matched" chain
   assign match      = ctl.valid && (key_ff == cmp_key);
   assign stat.match = match;
   assign stat.seen  = seen_in | match;
   assign key        = key_ff;
   assign value      = value_ff;

endmodule

`default_nettype wire

@@ hw/rtl/lru_key_value_cache.sv @@
// lru_key_value_cache: top level of the LRU key/value cache.
// Depends on lkv_pkg and lkv_cell.
//
// Usage
//   Request channel req_*: action (put, get, clear), key, write value.
//   A beat is taken when req_valid is high and req_stall is low.
//   Response channel rsp_*: status, read value, evicted key; one beat per
//   request, except the unused action code, which gives none and changes
//   nothing. The receiver holds a beat by raising rsp_stall.
//   Config channel csr_*: capacity register, written when csr_valid and
//   csr_ready are high; write only while no request is outstanding.
// Timing
//   Each request is resolved in the cycle it is taken; its response is
//   registered and shows in the next cycle. One request per cycle is taken
//   while the response register is free or being emptied; the row of
//   cells, ordered most recent first, shifts in that same cycle.
//   While rsp_stall holds a waiting beat, req_stall is raised.
// Reset
//   Synchronous: the store is empty, capacity is 16, no response pending.
`default_nettype none

module lru_key_value_cache
   import lkv_pkg::*;
#(
   parameter int CAPACITY_MAX = 16,
   parameter int VALUE_WIDTH  = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [ACTION_W-1:0]  req_action,
   input  wire logic [KEY_W-1:0]     req_key,
   input  wire logic [DATA_W-1:0]    req_write_value,
   // response channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [DATA_W-1:0]         rsp_read_value,
   output logic [KEY_W-1:0]          rsp_evicted_key,
   // configuration channel
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CFG_W-1:0]     csr_data
);

   localparam int CNT_W = $clog2(CAPACITY_MAX + 1);
   localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   // Registers
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]       rsp_read_value_ff, rsp_read_value_in;
   logic [KEY_W-1:0]        rsp_evicted_key_ff, rsp_evicted_key_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CFG_W-1:0]        capacity_ff, capacity_in;

   // Cell row
   lkv_cell_ctl_type        cell_ctl  [CAPACITY_MAX];
   lkv_cell_stat_type       cell_stat [CAPACITY_MAX];
   logic [KEY_W-1:0]        cell_key  [CAPACITY_MAX];
   logic [VALUE_WIDTH-1:0]  cell_value[CAPACITY_MAX];
   logic                    seen      [CAPACITY_MAX+1];
   logic                    cell_last [CAPACITY_MAX];
   logic [CAPACITY_MAX-1:0] match_vec;

   logic                    take;
   logic                    do_put, do_get, do_clear;
   logic                    any_hit, room;
   logic [CMP_W-1:0]        cap_eff, count_ext;
   logic [VALUE_WIDTH-1:0]  put_value, hit_value, front_value;
   logic [KEY_W-1:0]        tail_key;

   // Handshake
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign take      = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   assign do_put   = take && (req_action == ACT_PUT);
   assign do_get   = take && (req_action == ACT_GET);
   assign do_clear = take && (req_action == ACT_CLEAR);

   // Effective capacity: zero reads as one, clipped to the row length
   always_comb begin
      cap_eff = CMP_W'(capacity_ff);
      if (cap_eff == '0)
         cap_eff = CMP_W'(1);
      else if (cap_eff > CMP_W'(CAPACITY_MAX))
         cap_eff = CMP_W'(CAPACITY_MAX);
   end

   assign count_ext = CMP_W'(count_ff);
   assign room      = count_ext < cap_eff;
   assign put_value = VALUE_WIDTH'(req_write_value);
   assign seen[0]   = 1'b0;
   assign any_hit   = seen[CAPACITY_MAX];

   // Value and key picked off the row: hit entry and least recent entry
   always_comb begin
      hit_value = '0;
      tail_key  = '0;
      for (int i = 0; i < CAPACITY_MAX; i++) begin
         if (cell_stat[i].match)
            hit_value = hit_value | cell_value[i];
         if (cell_last[i])
            tail_key = tail_key | cell_key[i];
      end
   end

   // Entry entering at the most recent end
   assign front_value = (do_get && any_hit) ? hit_value : put_value;

   // Row of cells and their shift controls
   for (genvar i = 0; i < CAPACITY_MAX; i++) begin : g_cell
      logic [KEY_W-1:0]       left_key;
      logic [VALUE_WIDTH-1:0] left_value;
      logic                   live;

      assign live         = CNT_W'(i) < count_ff;
      assign cell_last[i] = CNT_W'(i + 1) == count_ff;

      // Hits rotate the hit entry to the front; inserts push one place;
      // evictions push the least recent entry off the live end
      always_comb begin
         cell_ctl[i].valid = live;
         if ((do_put || do_get) && any_hit)
            cell_ctl[i].shift = ~seen[i];
         else if (do_put && room)
            cell_ctl[i].shift = CNT_W'(i) <= count_ff;
         else if (do_put)
            cell_ctl[i].shift = live;
         else
            cell_ctl[i].shift = 1'b0;
      end

      if (i == 0) begin : g_front
         assign left_key   = req_key;
         assign left_value = front_value;
      end else begin : g_link
         assign left_key   = cell_key[i-1];
         assign left_value = cell_value[i-1];
      end

      lkv_cell #(
         .VW (VALUE_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[i]),
         .left_key   (left_key),
         .left_value (left_value),
         .cmp_key    (req_key),
         .seen_in    (seen[i]),
         .key        (cell_key[i]),
         .value      (cell_value[i]),
         .stat       (cell_stat[i])
      );

      assign seen[i+1]    = cell_stat[i].seen;
      assign match_vec[i] = cell_stat[i].match;
   end

   // Fill count, response beat and capacity register
   always_comb begin
      count_in           = count_ff;
      rsp_valid_in       = rsp_valid_ff & rsp_stall;
      rsp_status_in      = rsp_status_ff;
      rsp_read_value_in  = rsp_read_value_ff;
      rsp_evicted_key_in = rsp_evicted_key_ff;
      capacity_in        = (csr_valid && csr_ready) ? csr_data : capacity_ff;

      if (do_put || do_get || do_clear) begin
         rsp_valid_in       = 1'b1;
         rsp_read_value_in  = '0;
         rsp_evicted_key_in = '0;
         if (do_clear) begin
            rsp_status_in = ST_CLEARED;
            count_in      = '0;
         end else if (do_get) begin
            rsp_status_in = any_hit ? ST_HIT : ST_MISS;
            if (any_hit)
               rsp_read_value_in = DATA_W'(hit_value);
         end else if (any_hit) begin
            rsp_status_in = ST_UPDATED;
         end else if (room) begin
            rsp_status_in = ST_INSERTED;
            count_in      = count_ff + CNT_W'(1);
         end else begin
            rsp_status_in      = ST_EVICTED;
            rsp_evicted_key_in = tail_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         capacity_ff  <= CAP_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         capacity_ff  <= capacity_in;
      end
      rsp_status_ff      <= rsp_status_in;
      rsp_read_value_ff  <= rsp_read_value_in;
      rsp_evicted_key_ff <= rsp_evicted_key_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_evicted_key = rsp_evicted_key_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY_MAX))
      else $error("fill count beyond row length");

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("more than one live entry matches the key");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (do_put && !any_hit && room) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the fill count");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      do_clear |=> (count_ff == '0) && rsp_valid_ff && (rsp_status_ff == ST_CLEARED))
      else $error("clear did not empty the store");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("request stalled with no beat waiting");

endmodule

`default_nettype wire
